FILE: rtl/signature_table_lru_unit_assert.svh
// assertion macros shared by the signature table rtl
`ifndef SIGNATURE_TABLE_LRU_UNIT_ASSERT_SVH
`define SIGNATURE_TABLE_LRU_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("signature table assertion failed");

// next-cycle implication, disabled during reset
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("signature table assertion failed");

`endif

FILE: rtl/stl_pkg.sv
// package with word types and default sizes of the signature table
`default_nettype none
package stl_pkg;

   localparam int SIG_W        = 64;
   localparam int DATA_W       = 64;
   localparam int WAY_IDX_W    = 3;
   localparam int SET_BITS_DEF = 6;
   localparam int WAYS_DEF     = 4;

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_FILL   = 1'b1
   } action_type;

   typedef struct packed {
      action_type         action;
      logic [SIG_W-1:0]   signature;
      logic [DATA_W-1:0]  fill_data;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [WAY_IDX_W-1:0]  way_index;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/stl_row_ram.sv
// set row memory: one write port, one read port, registered read data
`default_nettype none
module stl_row_ram
   import stl_pkg::*;
#(
   parameter int ADDR_W = SET_BITS_DEF,
   parameter int ROW_W  = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ROW_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [ROW_W-1:0]  rd_data
);

   logic [ROW_W-1:0] mem [2**ADDR_W];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/stl_payload_mem.sv
// payload store, one data word per set and way
`default_nettype none
module stl_payload_mem
   import stl_pkg::*;
#(
   parameter int ADDR_W = SET_BITS_DEF + 2
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/stl_set_update.sv
// tag compare, victim choice and lru age update for one set row
`default_nettype none
module stl_set_update
   import stl_pkg::*;
#(
   parameter int TAG_W = SIG_W - SET_BITS_DEF,
   parameter int WAYS  = WAYS_DEF
) (
   input  wire logic [WAYS*(TAG_W+$clog2(WAYS)+1)-1:0] row_in,
   input  wire logic [TAG_W-1:0]                        tag,
   input  wire logic                                    fill,
   output logic                                         hit,
   output logic [((($clog2(WAYS+1)) > WAY_IDX_W) ? $clog2(WAYS+1) : WAY_IDX_W)-1:0] way,
   output logic [WAYS*(TAG_W+$clog2(WAYS)+1)-1:0]       row_out
);

   localparam int IW = $clog2(WAYS);
   localparam int WW = ($clog2(WAYS+1) > WAY_IDX_W) ? $clog2(WAYS+1) : WAY_IDX_W;
   localparam int AGE_BASE = WAYS;
   localparam int TAG_BASE = WAYS + WAYS*IW;

   logic [WAYS-1:0]  valid_v;
   logic [IW-1:0]    age_a [WAYS];
   logic [TAG_W-1:0] tag_a [WAYS];
   logic [WAYS-1:0]  match_v;
   logic [IW-1:0]    hit_way;
   logic [IW-1:0]    inv_way;
   logic [IW-1:0]    old_way;
   logic [IW-1:0]    victim;
   logic [IW-1:0]    old_age;
   logic             do_alloc;

   // unpack row: valid bits, then ages, then tags
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid_v[w] = row_in[w];
         age_a[w]   = row_in[AGE_BASE + w*IW +: IW];
         tag_a[w]   = row_in[TAG_BASE + w*TAG_W +: TAG_W];
      end
   end

   // parallel compare and first-of searches
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      old_way = IW'(WAYS-1);
      for (int w = 0; w < WAYS; w++) begin
         match_v[w] = valid_v[w] && (tag_a[w] == tag);
      end
      for (int w = WAYS-1; w >= 0; w--) begin
         if (match_v[w]) begin
            hit_way = IW'(w);
         end
         if (!valid_v[w]) begin
            inv_way = IW'(w);
         end
         if (age_a[w] == IW'(WAYS-1)) begin
            old_way = IW'(w);
         end
      end
      victim  = (&valid_v) ? old_way : inv_way;
      old_age = age_a[victim];
   end

   assign hit      = |match_v;
   assign do_alloc = fill && !hit;

   always_comb begin
      if (hit) begin
         way = WW'(hit_way);
      end else if (fill) begin
         way = WW'(victim);
      end else begin
         way = WW'(WAYS);
      end
   end

   // new row: victim becomes youngest, younger ways age by one
   always_comb begin
      row_out = row_in;
      if (do_alloc) begin
         for (int w = 0; w < WAYS; w++) begin
            if (IW'(w) == victim) begin
               row_out[w]                          = 1'b1;
               row_out[AGE_BASE + w*IW +: IW]      = '0;
               row_out[TAG_BASE + w*TAG_W +: TAG_W] = tag;
            end else if (age_a[w] < old_age) begin
               row_out[AGE_BASE + w*IW +: IW] = age_a[w] + IW'(1);
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/signature_table_lru_unit.sv
// top level of the set-associative signature table with lru replacement
`default_nettype none
`include "signature_table_lru_unit_assert.svh"
// Set-associative signature table, 2**SET_BITS sets of WAYS ways; ages move only on a fill miss.
// A word is taken at a clock edge where start is high and busy is low. Its
// result is registered in the access state and then shown on rsp_word,
// marked by rsp_valid for exactly one cycle; the receiver must take it then,
// there is no back-pressure. A new word is taken only once the last is done:
// the set row is read from the row memory (registered read) when a word is
// taken; in the access state the block compares all ways, picks the victim
// and, for a fill, writes the updated row back. After reset the block runs a
// clearing pass over all 2**SET_BITS rows of the row memory (all ways
// invalid, ages set to the way index) and holds busy high during it.
// A lookup never changes state. A fill that hits rewrites only the payload;
// a fill that misses takes the first invalid way, or else the oldest way.
// way_index is the matching way on a hit, the filled way on a fill miss and
// WAYS (low three bits) on a lookup miss.
module signature_table_lru_unit
   import stl_pkg::*;
#(
   parameter int SET_BITS = SET_BITS_DEF,
   parameter int WAYS     = WAYS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_word,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   // derived sizes
   localparam int TAG_W = SIG_W - SET_BITS;
   localparam int IW    = $clog2(WAYS);
   localparam int ROW_W = WAYS * (TAG_W + IW + 1);
   localparam int WW    = ($clog2(WAYS+1) > WAY_IDX_W) ? $clog2(WAYS+1) : WAY_IDX_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   state_type             state_ff;
   logic [SET_BITS-1:0]   clr_ff;
   req_type               req_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  accept;
   logic [SET_BITS-1:0]   set_ff_idx;
   logic [TAG_W-1:0]      tag_ff;
   logic [ROW_W-1:0]      rd_row;
   logic [ROW_W-1:0]      new_row;
   logic [ROW_W-1:0]      reset_row;
   logic                  row_we;
   logic [SET_BITS-1:0]   row_waddr;
   logic [ROW_W-1:0]      row_wdata;
   logic                  upd_hit;
   logic [WW-1:0]         upd_way;
   logic                  fill_ff;
   logic                  pay_we;

   // handshake
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // fields of the word in flight
   assign set_ff_idx = req_ff.signature[SET_BITS-1:0];
   assign tag_ff     = req_ff.signature[SIG_W-1:SET_BITS];
   assign fill_ff    = (req_ff.action == ACT_FILL);

   // row written by the clearing pass: all invalid, age equals way index
   always_comb begin
      reset_row = '0;
      for (int w = 0; w < WAYS; w++) begin
         reset_row[WAYS + w*IW +: IW] = IW'(w);
      end
   end

   // write port shared by clearing pass and write back of a fill
   assign row_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_ACCESS) && fill_ff);
   assign row_waddr = (state_ff == ST_CLEAR) ? clr_ff : set_ff_idx;
   assign row_wdata = (state_ff == ST_CLEAR) ? reset_row : new_row;
   assign pay_we    = (state_ff == ST_ACCESS) && fill_ff;

   stl_row_ram #(
      .ADDR_W (SET_BITS),
      .ROW_W  (ROW_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (accept),
      .rd_addr (req_word.signature[SET_BITS-1:0]),
      .rd_data (rd_row)
   );

   stl_set_update #(
      .TAG_W (TAG_W),
      .WAYS  (WAYS)
   ) u_set_update (
      .row_in  (rd_row),
      .tag     (tag_ff),
      .fill    (fill_ff),
      .hit     (upd_hit),
      .way     (upd_way),
      .row_out (new_row)
   );

   stl_payload_mem #(
      .ADDR_W (SET_BITS + IW)
   ) u_payload_mem (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr ({set_ff_idx, upd_way[IW-1:0]}),
      .wr_data (req_ff.fill_data)
   );

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + SET_BITS'(1);
               if (clr_ff == {SET_BITS{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_ACCESS;
               end
            end
            ST_ACCESS: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_CLEAR;
               clr_ff   <= '0;
            end
         endcase
      end
      // payload registers, no reset
      if (accept) begin
         req_ff <= req_word;
      end
      if (state_ff == ST_ACCESS) begin
         rsp_ff.hit       <= upd_hit;
         rsp_ff.way_index <= upd_way[WAY_IDX_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `STL_ASSERT_NEXT(a_accept_goes_busy, clock, reset, accept, busy && !rsp_valid)
   `STL_ASSERT_NEXT(a_access_gives_word, clock, reset, state_ff == ST_ACCESS, rsp_valid)
   `STL_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `STL_ASSERT_IMPLY(a_fill_way_in_range, clock, reset,
      (state_ff == ST_ACCESS) && fill_ff, upd_way < WW'(WAYS))

endmodule
`default_nettype wire
